### rtl/core/ssp_pkg.sv
package ssp_pkg;

   // Fixed field widths.
   localparam int POS_W     = 24;
   localparam int VEC_W     = 19;
   localparam int DIM_W     = 13;
   localparam int CSR_W     = 24;
   localparam int CSR_IDX_W = 3;

   // Datapath widths; all intermediates are exact.
   localparam int SXY_W     = 26;
   localparam int PROD_W    = 45;
   localparam int DETP_W    = 38;
   localparam int NXY_W     = 46;
   localparam int DET_W     = 39;
   localparam int SUM_W     = 47;
   localparam int HD_W      = 53;
   localparam int CN_W      = 60;
   localparam int CN_MAG_W  = 59;
   localparam int HD_MAG_W  = 52;
   localparam int NY_MAG_W  = 45;
   localparam int DET_MAG_W = 38;
   localparam int QUO_W     = 59;
   localparam int DIV_LAT   = QUO_W + 1;
   localparam int CTR_W     = QUO_W + 1;
   localparam int SIG_W     = QUO_W + 2;

   localparam int FRAC_BITS_DEF = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAM_POS_X   = 3'd0,
      CSR_CAM_POS_Y   = 3'd1,
      CSR_CAM_DIR_X   = 3'd2,
      CSR_CAM_DIR_Y   = 3'd3,
      CSR_CAM_PLANE_X = 3'd4,
      CSR_CAM_PLANE_Y = 3'd5,
      CSR_SCREEN_W    = 3'd6,
      CSR_SCREEN_H    = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DET_ZERO = 2'd1,
      STATUS_NY_ZERO  = 2'd2
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0]        cam_pos_x;
      logic [POS_W-1:0]        cam_pos_y;
      logic signed [VEC_W-1:0] cam_dir_x;
      logic signed [VEC_W-1:0] cam_dir_y;
      logic signed [VEC_W-1:0] cam_plane_x;
      logic signed [VEC_W-1:0] cam_plane_y;
      logic [DIM_W-1:0]        screen_width;
      logic [DIM_W-1:0]        screen_height;
   } cfg_type;

   typedef struct packed {
      logic neg_c;
      logic neg_d;
      logic det_zero;
      logic ny_zero;
   } flag_type;

   typedef struct packed {
      logic                 valid;
      logic [CN_MAG_W-1:0]  cn_mag;
      logic [HD_MAG_W-1:0]  hd_mag;
      logic [NY_MAG_W-1:0]  ny_mag;
      logic [DET_MAG_W-1:0] det_mag;
      flag_type             flags;
   } front_type;

endpackage

### rtl/core/ssp_div.sv
module ssp_div import ssp_pkg::*; #(
   parameter int NUM_W = 59,
   parameter int DEN_W = 45,
   parameter int Q_W   = QUO_W
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [Q_W-1:0]   quo
);

   // Restoring division, one quotient bit per stage. A quotient that does not
   // fit in Q_W bits comes out as all ones.
   localparam int T_W = Q_W + DEN_W;

   logic [T_W-1:0]   num_ext;
   logic [DEN_W-1:0] rem0;
   logic             ovf0;

   logic [DEN_W-1:0] rem_ff [0:Q_W];
   logic [Q_W-1:0]   low_ff [0:Q_W];
   logic [DEN_W-1:0] den_ff [0:Q_W];
   logic [Q_W-1:0]   quo_ff [0:Q_W];
   logic             ovf_ff [0:Q_W];

   logic [DEN_W-1:0] rem_in [1:Q_W];
   logic [Q_W-1:0]   quo_in [1:Q_W];

   assign num_ext = T_W'(num);
   assign rem0    = num_ext[T_W-1:Q_W];
   assign ovf0    = rem0 >= den;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= ovf0 ? '0 : rem0;
         low_ff[0] <= num_ext[Q_W-1:0];
         den_ff[0] <= den;
         quo_ff[0] <= '0;
         ovf_ff[0] <= ovf0;
      end
   end

   for (genvar k = 1; k <= Q_W; k++) begin : g_step
      logic [DEN_W:0] trial;
      logic           ge;

      always_comb begin
         trial     = {rem_ff[k-1], low_ff[k-1][Q_W-1]};
         ge        = trial >= {1'b0, den_ff[k-1]};
         rem_in[k] = ge ? DEN_W'(trial - {1'b0, den_ff[k-1]}) : trial[DEN_W-1:0];
         quo_in[k] = {quo_ff[k-1][Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_ff[k-1] << 1;
            den_ff[k] <= den_ff[k-1];
            quo_ff[k] <= quo_in[k];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   assign quo = ovf_ff[Q_W] ? '1 : quo_ff[Q_W];

endmodule

### rtl/core/ssp_front.sv
module ssp_front import ssp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  cfg_type                         cfg,
   input  logic                            in_valid,
   input  logic [POS_W-1:0]                obj_x,
   input  logic [POS_W-1:0]                obj_y,
   output front_type                       front,
   output logic [NY_MAG_W+FRAC_BITS-1:0]   dn_mag
);

   logic signed [SXY_W-1:0] half_unit;
   assign half_unit = SXY_W'(1) << (FRAC_BITS - 1);

   // Stage 1: sprite position relative to the camera.
   logic                    v1_ff;
   logic signed [SXY_W-1:0] sx_ff, sy_ff, sx_in, sy_in;

   assign sx_in = $signed({2'b00, obj_x}) - $signed({2'b00, cfg.cam_pos_x}) + half_unit;
   assign sy_in = $signed({2'b00, obj_y}) - $signed({2'b00, cfg.cam_pos_y}) + half_unit;

   // Stage 2: products.
   logic                     v2_ff;
   logic signed [PROD_W-1:0] dysx_ff, dxsy_ff, pxsy_ff, pysx_ff;
   logic signed [DETP_W-1:0] pxdy_ff, dxpy_ff;

   // Stage 3: transformed coordinates and determinant.
   logic                    v3_ff;
   logic signed [NXY_W-1:0] nx_ff, ny3_ff, nx_in, ny_in;
   logic signed [DET_W-1:0] det3_ff, det_in;

   assign nx_in  = NXY_W'(dysx_ff) - NXY_W'(dxsy_ff);
   assign ny_in  = NXY_W'(pxsy_ff) - NXY_W'(pysx_ff);
   assign det_in = DET_W'(pxdy_ff) - DET_W'(dxpy_ff);

   // Stage 4: column numerator sum and height numerator product.
   logic                    v4_ff;
   logic signed [SUM_W-1:0] s_ff;
   logic signed [HD_W-1:0]  hd4_ff;
   logic signed [NXY_W-1:0] ny4_ff;
   logic signed [DET_W-1:0] det4_ff;

   // Stage 5: column numerator product.
   logic                    v5_ff;
   logic signed [CN_W-1:0]  cn_ff;
   logic signed [HD_W-1:0]  hd5_ff;
   logic signed [NXY_W-1:0] ny5_ff;
   logic signed [DET_W-1:0] det5_ff;

   // Stage 6: magnitudes and signs for the dividers.
   front_type               front_ff, front_in;
   logic [NY_MAG_W+FRAC_BITS-1:0] dn_ff;
   logic                    ny_neg, det_neg;

   always_comb begin
      ny_neg            = ny5_ff[NXY_W-1];
      det_neg           = det5_ff[DET_W-1];
      front_in.valid    = v5_ff;
      front_in.cn_mag   = CN_MAG_W'(cn_ff[CN_W-1] ? -cn_ff : cn_ff);
      front_in.hd_mag   = HD_MAG_W'(hd5_ff[HD_W-1] ? -hd5_ff : hd5_ff);
      front_in.ny_mag   = NY_MAG_W'(ny_neg ? -ny5_ff : ny5_ff);
      front_in.det_mag  = DET_MAG_W'(det_neg ? -det5_ff : det5_ff);
      front_in.flags.neg_c    = cn_ff[CN_W-1] ^ ny_neg;
      front_in.flags.neg_d    = ny_neg ^ det_neg;
      front_in.flags.det_zero = det5_ff == '0;
      front_in.flags.ny_zero  = ny5_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
         v5_ff          <= 1'b0;
         front_ff.valid <= 1'b0;
      end else if (en) begin
         v1_ff          <= in_valid;
         v2_ff          <= v1_ff;
         v3_ff          <= v2_ff;
         v4_ff          <= v3_ff;
         v5_ff          <= v4_ff;
         front_ff.valid <= front_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sx_ff   <= sx_in;
         sy_ff   <= sy_in;
         dysx_ff <= cfg.cam_dir_y * sx_ff;
         dxsy_ff <= cfg.cam_dir_x * sy_ff;
         pxsy_ff <= cfg.cam_plane_x * sy_ff;
         pysx_ff <= cfg.cam_plane_y * sx_ff;
         pxdy_ff <= cfg.cam_plane_x * cfg.cam_dir_y;
         dxpy_ff <= cfg.cam_dir_x * cfg.cam_plane_y;
         nx_ff   <= nx_in;
         ny3_ff  <= ny_in;
         det3_ff <= det_in;
         s_ff    <= SUM_W'(ny3_ff) + SUM_W'(nx_ff);
         hd4_ff  <= $signed({1'b0, cfg.screen_height}) * det3_ff;
         ny4_ff  <= ny3_ff;
         det4_ff <= det3_ff;
         cn_ff   <= $signed({1'b0, cfg.screen_width[DIM_W-1:1]}) * s_ff;
         hd5_ff  <= hd4_ff;
         ny5_ff  <= ny4_ff;
         det5_ff <= det4_ff;
         front_ff.cn_mag  <= front_in.cn_mag;
         front_ff.hd_mag  <= front_in.hd_mag;
         front_ff.ny_mag  <= front_in.ny_mag;
         front_ff.det_mag <= front_in.det_mag;
         front_ff.flags   <= front_in.flags;
         dn_ff   <= {front_in.ny_mag, {FRAC_BITS{1'b0}}};
      end
   end

   assign front  = front_ff;
   assign dn_mag = dn_ff;

endmodule

### rtl/core/ssp_post.sv
module ssp_post import ssp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  cfg_type            cfg,
   input  logic               in_valid,
   input  flag_type           flags,
   input  logic [QUO_W-1:0]   quo_c,
   input  logic [QUO_W-1:0]   quo_h,
   input  logic [QUO_W-1:0]   quo_d,
   output logic               out_valid,
   output logic [1:0]         status,
   output logic signed [31:0] depth,
   output logic signed [15:0] center_col,
   output logic [15:0]        size_px,
   output logic [14:0]        top_row,
   output logic signed [15:0] bottom_row,
   output logic [14:0]        left_col,
   output logic signed [15:0] right_col
);

   // Stage 1: restore signs, saturate the depth.
   logic                    v1_ff;
   flag_type                flags_ff;
   logic signed [CTR_W-1:0] center_ff, center_in;
   logic [QUO_W-1:0]        hgt_ff;
   logic signed [31:0]      depth1_ff, depth_in;
   logic [QUO_W-1:0]        lim, mag;

   always_comb begin
      center_in = flags.neg_c ? -$signed({1'b0, quo_c}) : $signed({1'b0, quo_c});
      lim       = flags.neg_d ? (QUO_W'(1) << 31) : ((QUO_W'(1) << 31) - QUO_W'(1));
      mag       = (quo_d > lim) ? lim : quo_d;
      depth_in  = flags.neg_d ? -$signed(mag[31:0]) : $signed(mag[31:0]);
   end

   // Stage 2: rectangle and clamps.
   logic signed [SIG_W-1:0] h2, half, ctr, hh, ww;
   logic signed [SIG_W-1:0] top_v, bot_v, left_v, right_v, r1;
   logic                    v2_ff;
   logic [1:0]              status_ff, status_in;
   logic signed [31:0]      depth_ff, depth_o;
   logic signed [15:0]      center_ff2, center_o, bot_ff, bot_o, right_ff, right_o;
   logic [15:0]             size_ff, size_o;
   logic [14:0]             top_ff, top_o, left_ff, left_o;

   always_comb begin
      hh      = $signed(SIG_W'(cfg.screen_height));
      ww      = $signed(SIG_W'(cfg.screen_width));
      h2      = $signed(SIG_W'(cfg.screen_height >> 1));
      half    = $signed(SIG_W'(hgt_ff >> 1));
      ctr     = SIG_W'(center_ff);
      top_v   = h2 - half;
      bot_v   = h2 + half;
      left_v  = ctr - half;
      right_v = ctr + half;
      r1      = (right_v >= ww) ? ww - SIG_W'(1) : right_v;

      top_o   = top_v[SIG_W-1] ? '0 : top_v[14:0];
      bot_o   = (bot_v >= hh) ? 16'(hh - SIG_W'(1)) : bot_v[15:0];
      left_o  = left_v[SIG_W-1] ? '0 :
                (left_v > SIG_W'(32767)) ? 15'h7FFF : left_v[14:0];
      right_o = (r1 < -SIG_W'(32768)) ? -16'sd32768 : r1[15:0];
      if (ctr > SIG_W'(32767)) begin
         center_o = 16'sd32767;
      end else if (ctr < -SIG_W'(32768)) begin
         center_o = -16'sd32768;
      end else begin
         center_o = ctr[15:0];
      end
      size_o    = (hgt_ff > QUO_W'(65535)) ? 16'hFFFF : hgt_ff[15:0];
      depth_o   = depth1_ff;
      status_in = STATUS_OK;

      // A zero determinant or a zero depth blanks every other field.
      if (flags_ff.det_zero || flags_ff.ny_zero) begin
         status_in = flags_ff.det_zero ? STATUS_DET_ZERO : STATUS_NY_ZERO;
         top_o     = '0;
         bot_o     = '0;
         left_o    = '0;
         right_o   = '0;
         center_o  = '0;
         size_o    = '0;
         depth_o   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         flags_ff   <= flags;
         center_ff  <= center_in;
         hgt_ff     <= quo_h;
         depth1_ff  <= depth_in;
         status_ff  <= status_in;
         depth_ff   <= depth_o;
         center_ff2 <= center_o;
         size_ff    <= size_o;
         top_ff     <= top_o;
         bot_ff     <= bot_o;
         left_ff    <= left_o;
         right_ff   <= right_o;
      end
   end

   assign out_valid  = v2_ff;
   assign status     = status_ff;
   assign depth      = depth_ff;
   assign center_col = center_ff2;
   assign size_px    = size_ff;
   assign top_row    = top_ff;
   assign bottom_row = bot_ff;
   assign left_col   = left_ff;
   assign right_col  = right_ff;

endmodule

### rtl/core/sprite_screen_projection_unit.sv
// Sprite screen projection for a grid raycaster.
// The request channel (req_valid, req_ready, req_obj_x, req_obj_y) takes one
// sprite position per item. The response channel (rsp_valid, rsp_ready and
// the rsp_ fields) returns one projected item for each request, in order.
// Camera position, direction, plane and window size are written through the
// csr_ port one register per cycle; the user must do so only while the block
// is idle, which the block itself does not enforce. The pipeline is fully
// registered: six front stages form the camera-space coordinates and divider
// operands, three pipelined restoring dividers give one quotient bit per stage
// over sixty stages, and two back stages restore signs and clamp the rectangle.
// That is 68 register stages between an accepted request and its response on
// rsp_valid. One item is taken every cycle while the receiver keeps up.
// When the receiver stalls with a response waiting, the whole pipeline holds
// and req_ready drops, so no item is lost or repeated.
// Reset clears all valid bits and loads the default camera (direction 1.0
// along x, plane 0.66 along y, 640 by 480 window).
module sprite_screen_projection_unit import ssp_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [POS_W-1:0]     req_obj_x,
   input  logic [POS_W-1:0]     req_obj_y,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic signed [31:0]   rsp_depth,
   output logic signed [15:0]   rsp_center_col,
   output logic [15:0]          rsp_size_px,
   output logic [14:0]          rsp_top_row,
   output logic signed [15:0]   rsp_bottom_row,
   output logic [14:0]          rsp_left_col,
   output logic signed [15:0]   rsp_right_col,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   cfg_type cfg_ff;
   logic    en;

   // The pipeline advances unless a finished item sits unaccepted at the output.
   assign en        = ~rsp_valid | rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cam_pos_x     <= '0;
         cfg_ff.cam_pos_y     <= '0;
         cfg_ff.cam_dir_x     <= 19'sd65536;
         cfg_ff.cam_dir_y     <= '0;
         cfg_ff.cam_plane_x   <= '0;
         cfg_ff.cam_plane_y   <= 19'sd43254;
         cfg_ff.screen_width  <= 13'd640;
         cfg_ff.screen_height <= 13'd480;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CAM_POS_X:   cfg_ff.cam_pos_x     <= csr_wdata;
            CSR_CAM_POS_Y:   cfg_ff.cam_pos_y     <= csr_wdata;
            CSR_CAM_DIR_X:   cfg_ff.cam_dir_x     <= $signed(csr_wdata[VEC_W-1:0]);
            CSR_CAM_DIR_Y:   cfg_ff.cam_dir_y     <= $signed(csr_wdata[VEC_W-1:0]);
            CSR_CAM_PLANE_X: cfg_ff.cam_plane_x   <= $signed(csr_wdata[VEC_W-1:0]);
            CSR_CAM_PLANE_Y: cfg_ff.cam_plane_y   <= $signed(csr_wdata[VEC_W-1:0]);
            CSR_SCREEN_W:    cfg_ff.screen_width  <= csr_wdata[DIM_W-1:0];
            CSR_SCREEN_H:    cfg_ff.screen_height <= csr_wdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   front_type                     front;
   logic [NY_MAG_W+FRAC_BITS-1:0] dn_mag;

   ssp_front #(
      .FRAC_BITS (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg_ff),
      .in_valid (req_valid),
      .obj_x    (req_obj_x),
      .obj_y    (req_obj_y),
      .front    (front),
      .dn_mag   (dn_mag)
   );

   logic [QUO_W-1:0] quo_c, quo_h, quo_d;

   // Screen column: |w/2 * (ny + nx)| / |ny|.
   ssp_div #(.NUM_W(CN_MAG_W), .DEN_W(NY_MAG_W), .Q_W(QUO_W)) u_div_col (
      .clock (clock), .en (en), .num (front.cn_mag), .den (front.ny_mag), .quo (quo_c)
   );

   // Sprite size: |h * det| / |ny|.
   ssp_div #(.NUM_W(HD_MAG_W), .DEN_W(NY_MAG_W), .Q_W(QUO_W)) u_div_size (
      .clock (clock), .en (en), .num (front.hd_mag), .den (front.ny_mag), .quo (quo_h)
   );

   // Depth: |ny| scaled by the fraction bits over |det|.
   ssp_div #(.NUM_W(NY_MAG_W + FRAC_BITS), .DEN_W(DET_MAG_W), .Q_W(QUO_W)) u_div_depth (
      .clock (clock), .en (en), .num (dn_mag), .den (front.det_mag), .quo (quo_d)
   );

   // Valid bits and sign/status flags travel beside the dividers.
   logic     dly_vld_ff [0:DIV_LAT-1];
   flag_type dly_flg_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            dly_vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         dly_vld_ff[0] <= front.valid;
         for (int i = 1; i < DIV_LAT; i++) begin
            dly_vld_ff[i] <= dly_vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dly_flg_ff[0] <= front.flags;
         for (int i = 1; i < DIV_LAT; i++) begin
            dly_flg_ff[i] <= dly_flg_ff[i-1];
         end
      end
   end

   ssp_post u_post (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg_ff),
      .in_valid   (dly_vld_ff[DIV_LAT-1]),
      .flags      (dly_flg_ff[DIV_LAT-1]),
      .quo_c      (quo_c),
      .quo_h      (quo_h),
      .quo_d      (quo_d),
      .out_valid  (rsp_valid),
      .status     (rsp_status),
      .depth      (rsp_depth),
      .center_col (rsp_center_col),
      .size_px    (rsp_size_px),
      .top_row    (rsp_top_row),
      .bottom_row (rsp_bottom_row),
      .left_col   (rsp_left_col),
      .right_col  (rsp_right_col)
   );

endmodule
